// ----- sv/bdac_pkg.sv -----
package bdac_pkg;

    // field widths of the channels
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;

    // conversion sizing
    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_BITS   = DIGIT_W * MAX_DIGITS;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int POS_W      = $clog2(MAX_DIGITS);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(MAX_DIGITS - 1);

    // ascii code of the character zero
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [VALUE_BITS-1:0] t_bin;
    typedef logic [BCD_BITS-1:0]   t_bcd;
    typedef logic [DIGIT_W-1:0]    t_digit;

    // datapath controls from the sequencer
    typedef struct packed {
        logic load;
        logic step;
        logic shift_digit;
    } t_dab_ctrl;

endpackage

// ----- sv/bdac_in_if.sv -----
interface bdac_in_if
    import bdac_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/bdac_out_if.sv -----
interface bdac_out_if
    import bdac_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- sv/binary_to_decimal_ascii_core.sv -----
// unsigned 32-bit binary to decimal ascii text
//
// input channel i_in carries one 32-bit unsigned word per number. the output
// channel o_out carries one ascii digit ('0'..'9') per word, most significant
// first, leading zeros dropped; last marks the final digit of each number.
// a zero input gives the single word '0' with last set.
//
// a word is taken only while the converter is idle. conversion runs one
// shift-and-add-3 step per input bit, then walks the ten bcd digits one per
// cycle while the receiver does not stall. the first digit reaches the
// output register once the conversion and the walk over any leading zeros
// are done.
//
// a single output register sits at the end: a stall by the receiver freezes
// the digit walk, and the next input word can be accepted while the final
// digit of the previous number still waits there.
//
// reset (synchronous, active low) returns to idle and empties the output
// register; nothing is kept from one number to the next.
module binary_to_decimal_ascii_core
    import bdac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdac_in_if.sink     i_in,
    bdac_out_if.source  o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step_count;
    logic [POS_W-1:0]    r_emit_pos;
    logic                r_seen;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    t_dab_ctrl           ctrl;
    t_digit              top_digit;
    logic                advance;
    logic                at_last;
    logic                emit_now;

    // output slot free or being drained
    assign advance  = !r_out_valid || o_out.ready;
    assign at_last  = (r_emit_pos == LAST_POS);
    assign emit_now = (top_digit != '0) || r_seen || at_last;

    // datapath controls
    always_comb begin
        ctrl.load        = i_in.valid && (r_state == ST_IDLE);
        ctrl.step        = (r_state == ST_CONVERT);
        ctrl.shift_digit = (r_state == ST_EMIT) && advance;
    end

    bdac_dabble u_dabble (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_value     (i_in.value),
        .o_top_digit (top_digit)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step_count <= '0;
            r_emit_pos   <= '0;
            r_seen       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_char   <= ASCII_ZERO;
            r_out_last   <= 1'b0;
        end else begin
            // drained word with no new digit behind it
            if (o_out.ready && !ctrl.shift_digit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_state      <= ST_CONVERT;
                        r_step_count <= '0;
                        r_emit_pos   <= '0;
                        r_seen       <= 1'b0;
                    end
                end
                ST_CONVERT: begin
                    r_step_count <= r_step_count + STEP_W'(1);
                    if (r_step_count == LAST_STEP) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (advance) begin
                        r_out_valid <= emit_now;
                        r_out_char  <= ASCII_ZERO + CHAR_W'(top_digit);
                        r_out_last  <= at_last;
                        r_seen      <= emit_now;
                        r_emit_pos  <= r_emit_pos + POS_W'(1);
                        if (at_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.digit_char = r_out_char;
    assign o_out.last       = r_out_last;

`ifndef SYNTH
    // the final digit position always produces a word flagged last
    a_last_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && advance && at_last
        |=> (r_state == ST_IDLE) && r_out_valid && r_out_last)
        else $error("final digit not emitted with last");

    // a waiting digit that is not last means more digits are still to come
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> (r_state == ST_EMIT))
        else $error("non-final digit with no digit walk in progress");

    // digit walk starts from the top position
    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONVERT) |-> (r_emit_pos == '0) && !r_seen)
        else $error("digit walk state not cleared during conversion");

    // only decimal digit characters leave the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char >= ASCII_ZERO)
                     && (r_out_char <= ASCII_ZERO + CHAR_W'(9)))
        else $error("output character is not a decimal digit");
`endif

endmodule

// ----- sv/bdac_dabble.sv -----
module bdac_dabble
    import bdac_pkg::*;
(
    input  logic               i_clk,
    input  t_dab_ctrl          i_ctrl,
    input  logic [VALUE_W-1:0] i_value,
    output t_digit             o_top_digit
);

    t_bcd r_bcd;
    t_bcd n_bcd;
    t_bin r_bin;
    t_bin n_bin;
    t_bcd bcd_adj;

    // add 3 to every digit of 5 or more, all digits side by side
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // load, one shift step per bit, then one digit out per shift
    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        if (i_ctrl.load) begin
            n_bcd = '0;
            n_bin = VALUE_BITS'(i_value);
        end else if (i_ctrl.step) begin
            n_bcd = {bcd_adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
        end else if (i_ctrl.shift_digit) begin
            n_bcd = {r_bcd[BCD_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_top_digit = r_bcd[BCD_BITS-1 -: DIGIT_W];

endmodule

// ----- verif/bdac_test_pkg.sv -----
`timescale 1ns / 1ps

package bdac_test_pkg;
    import bdac_pkg::*;

    // one expected digit word on the output channel
    typedef struct {
        logic [VALUE_W-1:0] number;
        int                 number_idx;
        logic [CHAR_W-1:0]  digit_char;
        logic               last;
    } t_digit_expect;

    class digit_scoreboard;
        t_digit_expect pending_digits[$];
        int mismatches;
        int numbers_seen;
        int digits_checked;
        int ten_digit_numbers;

        function new();
            mismatches        = 0;
            numbers_seen      = 0;
            digits_checked    = 0;
            ten_digit_numbers = 0;
        endfunction

        function int pending_count();
            return pending_digits.size();
        endfunction

        // prints one line per mismatch and counts it
        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // accepted input word: work out its decimal digits, msd first
        function void note_value(logic [VALUE_W-1:0] value);
            longint unsigned rest;
            int unsigned     digs[MAX_DIGITS];
            int              top;
            t_digit_expect   exp;

            rest = longint'(value) & ((64'd1 << VALUE_BITS) - 1);
            // keep only the low digits the block can hold
            for (int k = 0; k < MAX_DIGITS; k++) begin
                digs[k] = int'(rest % 10);
                rest    = rest / 10;
            end
            top = 0;
            for (int k = MAX_DIGITS - 1; k > 0; k--) begin
                if (digs[k] != 0) begin
                    top = k;
                    break;
                end
            end
            if (top == MAX_DIGITS - 1)
                ten_digit_numbers++;
            for (int k = top; k >= 0; k--) begin
                exp.number     = value;
                exp.number_idx = numbers_seen;
                exp.digit_char = ASCII_ZERO + CHAR_W'(digs[k]);
                exp.last       = (k == 0);
                pending_digits.push_back(exp);
            end
            numbers_seen++;
        endfunction

        // accepted output word against the oldest expectation
        task check_digit(logic [CHAR_W-1:0] digit_char, logic last);
            t_digit_expect exp;

            if (pending_digits.size() == 0) begin
                report_mismatch($sformatf("digit word %0d last %b with nothing expected",
                                          digit_char, last));
            end else begin
                exp = pending_digits.pop_front();
                digits_checked++;
                if (digit_char !== exp.digit_char)
                    report_mismatch($sformatf("number #%0d (%0d): digit_char %0d, want %0d",
                                              exp.number_idx, exp.number, digit_char,
                                              exp.digit_char));
                if (last !== exp.last)
                    report_mismatch($sformatf("number #%0d (%0d): last %b, want %b",
                                              exp.number_idx, exp.number, last, exp.last));
            end
        endtask
    endclass

endpackage

// ----- verif/binary_to_decimal_ascii_core_test.sv -----
`timescale 1ns / 1ps

module binary_to_decimal_ascii_core_test;
    import bdac_pkg::*;
    import bdac_test_pkg::*;

    localparam int RANDOM_NUMBERS = 250;
    localparam int CALM_TAIL      = 40;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int CYCLE_LIMIT    = 500000;

    logic clk;
    logic rst_n;
    bit   idling_on;
    bit   long_hold_asked;
    bit   long_hold_done;
    int   cycles;

    digit_scoreboard digit_sb;

    bdac_in_if  in_ch();
    bdac_out_if out_ch();

    binary_to_decimal_ascii_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 10 ns clock
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("binary_to_decimal_ascii_core_test failed");
            $finish;
        end
    end

    // watch both channels at the rising edge
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready)
            digit_sb.note_value(in_ch.value);
        if (rst_n && out_ch.valid && out_ch.ready)
            digit_sb.check_digit(out_ch.digit_char, out_ch.last);
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_asked && !long_hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // offer one word and hold it until taken; returns at a falling edge
    task send_number(logic [VALUE_W-1:0] number);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= $urandom;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= number;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // random number with a spread of digit counts
    function automatic logic [VALUE_W-1:0] pick_number();
        longint unsigned lo;
        longint unsigned hi;
        int              ndig;

        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 20);
            default: begin
                ndig = $urandom_range(1, MAX_DIGITS);
                lo = (ndig == 1) ? 0 : 1;
                hi = 1;
                for (int k = 0; k < ndig; k++)
                    hi = hi * 10;
                for (int k = 1; k < ndig; k++)
                    lo = lo * 10;
                hi = hi - 1;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                return $urandom_range(int'(hi), int'(lo));
            end
        endcase
    endfunction

    // directed numbers: zero, digit-count boundaries, bit patterns
    logic [VALUE_W-1:0] directed_numbers[] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999,
        32'd1000, 32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999,
        32'd1000000, 32'd9999999, 32'd10000000, 32'd99999999, 32'd1000000000,
        32'd999999999, 32'd1234567890, 32'h8000_0000, 32'h5555_5555,
        32'hAAAA_AAAA, 32'hFFFF_FFFF
    };

    initial begin
        digit_sb        = new();
        idling_on       = 1'b0;
        long_hold_asked = 1'b0;
        long_hold_done  = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.value     = '0;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, back to back
        foreach (directed_numbers[k])
            send_number(directed_numbers[k]);

        // random part with idling on both sides, then a calm tail
        idling_on = 1'b1;
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            if (n == RANDOM_NUMBERS / 3)
                long_hold_asked = 1'b1;
            if (n == RANDOM_NUMBERS - CALM_TAIL)
                idling_on = 1'b0;
            send_number(pick_number());
        end
        in_ch.valid <= 1'b0;

        // drain
        while (digit_sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digit_sb.pending_count() != 0)
            digit_sb.report_mismatch($sformatf("%0d digit words never arrived",
                                               digit_sb.pending_count()));

        $display("covered %0d numbers (%0d with ten digits), %0d digit words checked",
                 digit_sb.numbers_seen, digit_sb.ten_digit_numbers,
                 digit_sb.digits_checked);
        $display("random idling on both channels and one %0d-cycle receiver hold-off",
                 LONG_HOLD);
        if (digit_sb.mismatches == 0) begin
            $display("binary_to_decimal_ascii_core_test passed");
        end else begin
            $display("binary_to_decimal_ascii_core_test failed");
        end
        $finish;
    end

endmodule
